FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the key matrix press classifier modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define KMPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define KMPC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: sv/kmpc_pkg.sv
// ----------------------------------------------------------------------------
// kmpc_pkg
// Types and constants shared by the key matrix press classifier modules.
// ----------------------------------------------------------------------------
package kmpc_pkg;

   localparam int THRESH_WIDTH = 16;
   localparam int LEVELS_WIDTH = 3;
   localparam int DRIVE_WIDTH  = 4;
   localparam int KEY_WIDTH    = 4;
   localparam int PEND_WIDTH   = 4;

   localparam logic [THRESH_WIDTH-1:0] SHORT_THRESH_RESET = 16'd3;
   localparam logic [THRESH_WIDTH-1:0] LONG_THRESH_RESET  = 16'd100;

   // configuration register indexes
   localparam logic CSR_SHORT_THRESH = 1'b0;
   localparam logic CSR_LONG_THRESH  = 1'b1;

   // request actions
   localparam logic ACT_SCAN = 1'b0;
   localparam logic ACT_TAKE = 1'b1;

   typedef struct packed {
      logic start;     // capture request, reset row walk
      logic cnt_rd;    // read hold counter of current key
      logic scan_ev;   // evaluate current key, write counter, maybe push
      logic pop_rd;    // read newest stack entry
      logic pop_ev;    // pop newest entry if any
      logic load_rsp;  // load response register
   } kmpc_cmd_type;

   typedef struct packed {
      logic last_row;
   } kmpc_status_type;

endpackage

FILE: sv/kmpc_ram.sv
// ----------------------------------------------------------------------------
// kmpc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kmpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/kmpc_ctrl.sv
// ----------------------------------------------------------------------------
// kmpc_ctrl
// Sequencer: walks the rows of a scanned column or pops the event stack,
// then hands the result to the response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmpc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_action,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output kmpc_pkg::kmpc_cmd_type    cmd,
   input  kmpc_pkg::kmpc_status_type status
);

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_SCAN_RD = 6'b000010,
      ST_SCAN_EV = 6'b000100,
      ST_POP_RD  = 6'b001000,
      ST_POP_EV  = 6'b010000,
      ST_FINISH  = 6'b100000
   } kmpc_state_type;

   kmpc_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = (req_action == kmpc_pkg::ACT_TAKE) ? ST_POP_RD : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = ST_SCAN_EV;
         end
         ST_SCAN_EV: begin
            cmd.scan_ev = 1'b1;
            state_in    = status.last_row ? ST_FINISH : ST_SCAN_RD;
         end
         ST_POP_RD: begin
            cmd.pop_rd = 1'b1;
            state_in   = ST_POP_EV;
         end
         ST_POP_EV: begin
            cmd.pop_ev = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `KMPC_ASSERT_NEVER(a_no_rsp_overwrite, clock, reset,
      cmd.load_rsp && rsp_valid_ff && !rsp_ready, "response overwritten while stalled")
   `KMPC_ASSERT(a_take_goes_to_pop, clock, reset,
      (req_valid && req_ready && req_action == kmpc_pkg::ACT_TAKE) |=> state_ff == ST_POP_RD,
      "take request did not start a pop")

endmodule

FILE: sv/kmpc_datapath.sv
// ----------------------------------------------------------------------------
// kmpc_datapath
// Hold counters, press classification, event stack, thresholds and the
// response register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmpc_datapath #(
   parameter int COLUMNS     = 4,
   parameter int ROWS        = 3,
   parameter int STACK_DEPTH = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  kmpc_pkg::kmpc_cmd_type                   cmd,
   output kmpc_pkg::kmpc_status_type                status,
   input  logic [kmpc_pkg::LEVELS_WIDTH-1:0]        req_row_levels,
   input  logic                                    csr_valid,
   input  logic                                    csr_index,
   input  logic [kmpc_pkg::THRESH_WIDTH-1:0]        csr_data,
   output logic [kmpc_pkg::DRIVE_WIDTH-1:0]         rsp_column_drive,
   output logic                                    rsp_event_valid,
   output logic [kmpc_pkg::KEY_WIDTH-1:0]           rsp_key_index,
   output logic                                    rsp_long_press,
   output logic [kmpc_pkg::PEND_WIDTH-1:0]          rsp_pending_events
);

   localparam int KEY_COUNT = COLUMNS * ROWS;
   localparam int KW   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam int CW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int FW   = $clog2(STACK_DEPTH + 1);
   localparam int CMPW = (COUNT_WIDTH > kmpc_pkg::THRESH_WIDTH) ? COUNT_WIDTH
                                                                : kmpc_pkg::THRESH_WIDTH;
   localparam int SW   = kmpc_pkg::KEY_WIDTH + 1;

   logic [kmpc_pkg::THRESH_WIDTH-1:0] short_ff, long_ff;
   logic [CW-1:0]                     col_ff;
   logic [RW-1:0]                     row_ff;
   logic [KW-1:0]                     key_ff;
   logic [ROWS-1:0]                   lvl_ff;
   logic [FW-1:0]                     free_ff, free_in;
   logic [KEY_COUNT-1:0]              cvld_ff;
   logic                              cvld_q_ff;
   logic                              res_valid_ff;
   logic [kmpc_pkg::KEY_WIDTH-1:0]    res_key_ff;
   logic                              res_long_ff;

   logic [31:0]             levels32;
   logic [31:0]             key32;
   logic [31:0]             col32;
   logic [31:0]             pend32;
   logic [COUNT_WIDTH-1:0]  cnt_q;
   logic [COUNT_WIDTH-1:0]  cnt;
   logic [COUNT_WIDTH-1:0]  cnt_new;
   logic [CMPW-1:0]         cnt_ext, short_ext, long_ext;
   logic                    pressed, is_short, is_long, push;
   logic [FW-1:0]           free_dec;
   logic [FW-1:0]           pend_w;
   logic [SW-1:0]           stk_q;
   logic [kmpc_pkg::DRIVE_WIDTH-1:0] drive;

   assign levels32 = 32'(req_row_levels);
   assign key32    = 32'(key_ff);
   assign col32    = 32'(col_ff);

   // --- classification of the current key ---
   assign cnt       = cvld_q_ff ? cnt_q : '0;
   assign cnt_ext   = CMPW'(cnt);
   assign short_ext = CMPW'(short_ff);
   assign long_ext  = CMPW'(long_ff);
   assign pressed   = !lvl_ff[0];
   assign cnt_new   = !pressed ? '0 : ((&cnt) ? cnt : cnt + 1'b1);
   assign is_short  = !pressed && (cnt_ext >= short_ext) && (cnt_ext <= long_ext);
   assign is_long   = !pressed && (cnt_ext > long_ext);
   assign push      = cmd.scan_ev && (is_short || is_long);

   // pushing onto a full stack drops everything first
   assign free_dec = (free_ff == '0) ? FW'(STACK_DEPTH - 1) : free_ff - 1'b1;

   always_comb begin
      free_in = free_ff;
      if (push) begin
         free_in = free_dec;
      end else if (cmd.pop_ev && (free_ff < FW'(STACK_DEPTH))) begin
         free_in = free_ff + 1'b1;
      end
   end

   kmpc_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (KEY_COUNT)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cmd.scan_ev),
      .wr_addr (key_ff),
      .wr_data (cnt_new),
      .rd_en   (cmd.cnt_rd),
      .rd_addr (key_ff),
      .rd_data (cnt_q)
   );

   kmpc_ram #(
      .WIDTH (SW),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (free_dec[AW-1:0]),
      .wr_data ({key32[kmpc_pkg::KEY_WIDTH-1:0], is_long}),
      .rd_en   (cmd.pop_rd),
      .rd_addr (free_ff[AW-1:0]),
      .rd_data (stk_q)
   );

   // --- control state ---
   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff <= kmpc_pkg::SHORT_THRESH_RESET;
         long_ff  <= kmpc_pkg::LONG_THRESH_RESET;
         col_ff   <= '0;
         free_ff  <= FW'(STACK_DEPTH);
         cvld_ff  <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               kmpc_pkg::CSR_SHORT_THRESH: short_ff <= csr_data;
               kmpc_pkg::CSR_LONG_THRESH:  long_ff  <= csr_data;
               default: ;
            endcase
         end
         free_ff <= free_in;
         if (cmd.scan_ev) begin
            cvld_ff[key_ff] <= 1'b1;
            if (status.last_row) begin
               col_ff <= (col_ff == CW'(COLUMNS - 1)) ? '0 : col_ff + 1'b1;
            end
         end
      end
   end

   // --- row walk and result staging ---
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row_ff       <= '0;
         key_ff       <= KW'(int'(col_ff) * ROWS);
         lvl_ff       <= levels32[ROWS-1:0];
         res_valid_ff <= 1'b0;
         res_key_ff   <= '0;
         res_long_ff  <= 1'b0;
      end
      if (cmd.cnt_rd) begin
         cvld_q_ff <= cvld_ff[key_ff];
      end
      if (cmd.scan_ev) begin
         row_ff <= row_ff + 1'b1;
         key_ff <= key_ff + 1'b1;
         lvl_ff <= lvl_ff >> 1;
      end
      if (cmd.pop_ev && (free_ff < FW'(STACK_DEPTH))) begin
         res_valid_ff <= 1'b1;
         res_key_ff   <= stk_q[SW-1:1];
         res_long_ff  <= stk_q[0];
      end
   end

   assign status.last_row = (row_ff == RW'(ROWS - 1));

   // --- response register ---
   assign drive  = (col32 < 32'd4) ? ~(4'b0001 << col32[1:0]) : 4'hF;
   assign pend_w = FW'(STACK_DEPTH) - free_ff;
   assign pend32 = 32'(pend_w);

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_column_drive   <= drive;
         rsp_event_valid    <= res_valid_ff;
         rsp_key_index      <= res_key_ff;
         rsp_long_press     <= res_long_ff;
         rsp_pending_events <= pend32[kmpc_pkg::PEND_WIDTH-1:0];
      end
   end

   `KMPC_ASSERT(a_free_range, clock, reset, free_ff <= FW'(STACK_DEPTH),
      "free slot count beyond stack depth")
   `KMPC_ASSERT(a_col_range, clock, reset, col_ff <= CW'(COLUMNS - 1),
      "column pointer beyond last column")
   `KMPC_ASSERT(a_full_push_restarts, clock, reset,
      (push && free_ff == '0) |=> free_ff == FW'(STACK_DEPTH - 1),
      "push on full stack did not restart the stack")

endmodule

FILE: sv/key_matrix_press_classifier.sv
// ----------------------------------------------------------------------------
// key_matrix_press_classifier
// Key matrix scanner with short/long press classification and an event stack.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready): req_action selects a scan of the
//   current column (req_row_levels, active low) or a take of the newest event.
//   Response channel (rsp_valid/rsp_ready): one response per request, with the
//   next column strobe, the popped event if any and the stack fill.
//   Config channel (csr_valid/csr_ready): csr_ready is always high; index 0 is
//   the short threshold, index 1 the long threshold. Write only when idle.
// Timing:
//   One request at a time. For a scan, each row reads its hold counter from
//   RAM and then evaluates and writes it back, then the response register
//   loads and raises rsp_valid. A take reads the stack RAM, pops, then loads
//   the response register. The response register frees the input side, so
//   a new request is accepted while the previous response is still waiting.
// Reset: column pointer to 0, all hold counters read as zero, stack empty,
//   thresholds 3 and 100. A stalled receiver holds the response; a finished
//   request then waits until the response register is free.
// ----------------------------------------------------------------------------
module key_matrix_press_classifier #(
   parameter int COLUMNS     = 4,
   parameter int ROWS        = 3,
   parameter int STACK_DEPTH = 8,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [kmpc_pkg::LEVELS_WIDTH-1:0]  req_row_levels,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [kmpc_pkg::DRIVE_WIDTH-1:0]   rsp_column_drive,
   output logic                              rsp_event_valid,
   output logic [kmpc_pkg::KEY_WIDTH-1:0]     rsp_key_index,
   output logic                              rsp_long_press,
   output logic [kmpc_pkg::PEND_WIDTH-1:0]    rsp_pending_events,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [kmpc_pkg::THRESH_WIDTH-1:0]  csr_data
);

   kmpc_pkg::kmpc_cmd_type    cmd;
   kmpc_pkg::kmpc_status_type status;

   assign csr_ready = 1'b1;

   kmpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   kmpc_datapath #(
      .COLUMNS     (COLUMNS),
      .ROWS        (ROWS),
      .STACK_DEPTH (STACK_DEPTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_row_levels     (req_row_levels),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_column_drive   (rsp_column_drive),
      .rsp_event_valid    (rsp_event_valid),
      .rsp_key_index      (rsp_key_index),
      .rsp_long_press     (rsp_long_press),
      .rsp_pending_events (rsp_pending_events)
   );

endmodule
